@@ src/sgps_pkg.sv @@
// Shared constants, codes and types of the strip-chart point scaler.
package sgps_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int MAX_POINTS    = 64;

  localparam int ROW_MARGIN = 9;
  localparam int MIN_STEP   = 2;
  localparam int ROW_H      = SCREEN_HEIGHT - 2 * ROW_MARGIN;
  localparam int HW         = $clog2(ROW_H + 1);

  localparam int VAL_W  = 16;
  localparam int ROW_W  = 6;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 7;
  localparam int FUNC_W = 2;

  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int MEM_W = 2 * VAL_W + ROW_W;

  localparam int DVD_W = VAL_W + HW;
  localparam int DVS_W = VAL_W;

  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_FIELDS_W = 2 * VAL_W + ROW_W + CNT_W;

  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO      = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/sgps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/sgps_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module sgps_div (
  input  logic                clk,
  input  logic                rst_n,
  input  sgps_pkg::div_req_t  req,
  output sgps_pkg::div_rsp_t  rsp
);
  import sgps_pkg::*;

  localparam int ITER_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_dif;
  logic           fits;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign fits    = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ src/scrolling_graph_point_scaler.sv @@
// Strip-chart point scaler: scrolling sample history with pixel-row scaling.
//
// One item is in work at a time; the next is taken once its result has
// been placed in the output register. A read beyond the count skips the
// RAM access. Append and restart time is set by the bit-serial divider
// that computes the row (and, on restart, the point count); the fill pass
// writes one entry a cycle through the single RAM write port.
// Configuration changes take effect at the next restart item.
module scrolling_graph_point_scaler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] sample, [21:16] entry_index, [23:22] zero
  input  logic [sgps_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] func
  input  logic [sgps_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] raw_value, [31:16] clamped_value, [37:32] pixel_row,
  // [43:38] point_count, [47:44] zero
  output logic [sgps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] status
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgps_pkg::VAL_W-1:0]          cfg_data
);
  import sgps_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_NGO   = 4'd1;
  localparam logic [ST_W-1:0] S_NWAIT = 4'd2;
  localparam logic [ST_W-1:0] S_CLAMP = 4'd3;
  localparam logic [ST_W-1:0] S_MUL   = 4'd4;
  localparam logic [ST_W-1:0] S_RGO   = 4'd5;
  localparam logic [ST_W-1:0] S_RWAIT = 4'd6;
  localparam logic [ST_W-1:0] S_FILL  = 4'd7;
  localparam logic [ST_W-1:0] S_RD    = 4'd8;
  localparam logic [ST_W-1:0] S_RDW   = 4'd9;
  localparam logic [ST_W-1:0] S_DONE  = 4'd10;

  localparam int SUM_W = ((PW > IDX_W) ? PW : IDX_W) + 1;
  localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic signed [VAL_W-1:0] reg_low_r, reg_low_nxt;
  logic signed [VAL_W-1:0] reg_high_r, reg_high_nxt;
  logic [STEP_W-1:0]       reg_step_r, reg_step_nxt;
  logic signed [VAL_W-1:0] reg_zero_r, reg_zero_nxt;
  logic signed [VAL_W-1:0] lim_low_r, lim_low_nxt;
  logic signed [VAL_W-1:0] lim_high_r, lim_high_nxt;
  logic [AW-1:0]           oldest_r, oldest_nxt;
  logic [PW-1:0]           points_r, points_nxt;

  logic [FUNC_W-1:0]       func_r, func_nxt;
  logic signed [VAL_W-1:0] sample_r, sample_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [PW-1:0]           n_r, n_nxt;
  logic signed [VAL_W-1:0] cl_r, cl_nxt;
  logic [DVD_W-1:0]        prod_r, prod_nxt;
  logic [DVS_W-1:0]        span_r, span_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [PW-1:0]           fill_cnt_r, fill_cnt_nxt;
  logic [VAL_W-1:0]        res_raw_r, res_raw_nxt;
  logic [VAL_W-1:0]        res_cl_r, res_cl_nxt;
  logic [ROW_W-1:0]        res_row_r, res_row_nxt;
  logic                    res_st_r, res_st_nxt;
  logic [VAL_W-1:0]        out_raw_r, out_raw_nxt;
  logic [VAL_W-1:0]        out_cl_r, out_cl_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                    out_st_r, out_st_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [MEM_W-1:0] mem_rdata;

  logic signed [VAL_W-1:0] clamp_in;
  logic signed [VAL_W-1:0] clamp_out;
  logic [STEP_W-1:0]       step_eff;
  logic [VAL_W:0]          rel_full;
  logic [VAL_W:0]          span_full;
  logic [ROW_W-1:0]        row_calc;
  logic [SUM_W-1:0]        idx_e;
  logic [SUM_W-1:0]        pts_e;
  logic [SUM_W-1:0]        rd_sum;
  logic [SUM_W-1:0]        rd_wrap;
  logic [PW-1:0]           next_ptr;

  sgps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sgps_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign clamp_in  = (func_r == FUNC_RESTART) ? reg_zero_r : sample_r;
  assign clamp_out = (clamp_in > lim_high_r) ? lim_high_r :
                     (clamp_in < lim_low_r)  ? lim_low_r  : clamp_in;
  assign step_eff  = (reg_step_r < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : reg_step_r;
  assign rel_full  = {cl_r[VAL_W-1], cl_r} - {lim_low_r[VAL_W-1], lim_low_r};
  assign span_full = {lim_high_r[VAL_W-1], lim_high_r} - {lim_low_r[VAL_W-1], lim_low_r};
  assign row_calc  = (span_r == '0) ? ROW_W'(ROW_MARGIN + ROW_H) :
                     ROW_W'(ROW_MARGIN + ROW_H) - div_rsp.quotient[ROW_W-1:0];
  assign idx_e     = SUM_W'(idx_r);
  assign pts_e     = SUM_W'(points_r);
  assign rd_sum    = SUM_W'(oldest_r) + idx_e;
  assign rd_wrap   = (rd_sum >= pts_e) ? rd_sum - pts_e : rd_sum;
  assign next_ptr  = PW'(oldest_r) + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    reg_low_nxt   = reg_low_r;
    reg_high_nxt  = reg_high_r;
    reg_step_nxt  = reg_step_r;
    reg_zero_nxt  = reg_zero_r;
    lim_low_nxt   = lim_low_r;
    lim_high_nxt  = lim_high_r;
    oldest_nxt    = oldest_r;
    points_nxt    = points_r;
    func_nxt      = func_r;
    sample_nxt    = sample_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    cl_nxt        = cl_r;
    prod_nxt      = prod_r;
    span_nxt      = span_r;
    row_nxt       = row_r;
    fill_cnt_nxt  = fill_cnt_r;
    res_raw_nxt   = res_raw_r;
    res_cl_nxt    = res_cl_r;
    res_row_nxt   = res_row_r;
    res_st_nxt    = res_st_r;
    out_raw_nxt   = out_raw_r;
    out_cl_nxt    = out_cl_r;
    out_row_nxt   = out_row_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    div_req       = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    if (cfg_valid) begin
      case (cfg_index)
        REG_AXIS_LOW:  reg_low_nxt  = cfg_data;
        REG_AXIS_HIGH: reg_high_nxt = cfg_data;
        REG_STEP:      reg_step_nxt = cfg_data[STEP_W-1:0];
        REG_ZERO:      reg_zero_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tuser;
          sample_nxt = in_tdata[VAL_W-1:0];
          idx_nxt    = in_tdata[VAL_W+IDX_W-1:VAL_W];
          case (in_tuser)
            FUNC_RESTART: begin
              if (reg_low_r <= reg_high_r) begin
                lim_low_nxt  = reg_low_r;
                lim_high_nxt = reg_high_r;
              end else begin
                lim_low_nxt  = reg_high_r;
                lim_high_nxt = reg_low_r;
              end
              state_nxt = S_NGO;
            end
            FUNC_APPEND: state_nxt = S_CLAMP;
            FUNC_READ:   state_nxt = S_RD;
            default: ;
          endcase
        end
      end
      S_NGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(SCREEN_WIDTH - 2);
        div_req.divisor  = DVS_W'(step_eff);
        state_nxt        = S_NWAIT;
      end
      S_NWAIT: begin
        if (div_rsp.done) begin
          n_nxt     = (div_rsp.quotient > DVD_W'(MAX_POINTS)) ? PW'(MAX_POINTS) :
                      div_rsp.quotient[PW-1:0];
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cl_nxt    = clamp_out;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = DVD_W'(rel_full[VAL_W-1:0]) * DVD_W'(ROW_H);
        span_nxt  = span_full[VAL_W-1:0];
        state_nxt = S_RGO;
      end
      S_RGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = span_r;
        state_nxt        = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_rsp.done) begin
          row_nxt = row_calc;
          if (func_r == FUNC_RESTART) begin
            fill_cnt_nxt = '0;
            state_nxt    = S_FILL;
          end else begin
            if (points_r != '0) begin
              mem_we     = 1'b1;
              mem_waddr  = oldest_r;
              mem_wdata  = {sample_r, cl_r, row_calc};
              oldest_nxt = (next_ptr >= points_r) ? '0 : next_ptr[AW-1:0];
            end
            res_raw_nxt = sample_r;
            res_cl_nxt  = cl_r;
            res_row_nxt = row_calc;
            res_st_nxt  = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end
      S_FILL: begin
        if (fill_cnt_r < n_r) begin
          mem_we       = 1'b1;
          mem_waddr    = fill_cnt_r[AW-1:0];
          mem_wdata    = {cl_r, cl_r, row_r};
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end else begin
          points_nxt  = n_r;
          oldest_nxt  = '0;
          res_raw_nxt = cl_r;
          res_cl_nxt  = cl_r;
          res_row_nxt = row_r;
          res_st_nxt  = 1'b0;
          state_nxt   = S_DONE;
        end
      end
      S_RD: begin
        if (idx_e >= pts_e) begin
          res_raw_nxt = '0;
          res_cl_nxt  = '0;
          res_row_nxt = '0;
          res_st_nxt  = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          mem_raddr = rd_wrap[AW-1:0];
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        res_raw_nxt = mem_rdata[MEM_W-1:VAL_W+ROW_W];
        res_cl_nxt  = mem_rdata[VAL_W+ROW_W-1:ROW_W];
        res_row_nxt = mem_rdata[ROW_W-1:0];
        res_st_nxt  = 1'b0;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_raw_nxt   = res_raw_r;
          out_cl_nxt    = res_cl_r;
          out_row_nxt   = res_row_r;
          out_cnt_nxt   = CNT_W'(points_r);
          out_st_nxt    = res_st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      reg_low_r   <= '0;
      reg_high_r  <= VAL_W'(100);
      reg_step_r  <= STEP_W'(MIN_STEP);
      reg_zero_r  <= '0;
      lim_low_r   <= '0;
      lim_high_r  <= VAL_W'(100);
      oldest_r    <= '0;
      points_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      reg_low_r   <= reg_low_nxt;
      reg_high_r  <= reg_high_nxt;
      reg_step_r  <= reg_step_nxt;
      reg_zero_r  <= reg_zero_nxt;
      lim_low_r   <= lim_low_nxt;
      lim_high_r  <= lim_high_nxt;
      oldest_r    <= oldest_nxt;
      points_r    <= points_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    sample_r   <= sample_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    cl_r       <= cl_nxt;
    prod_r     <= prod_nxt;
    span_r     <= span_nxt;
    row_r      <= row_nxt;
    fill_cnt_r <= fill_cnt_nxt;
    res_raw_r  <= res_raw_nxt;
    res_cl_r   <= res_cl_nxt;
    res_row_r  <= res_row_nxt;
    res_st_r   <= res_st_nxt;
    out_raw_r  <= out_raw_nxt;
    out_cl_r   <= out_cl_nxt;
    out_row_r  <= out_row_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_cnt_r, out_row_r, out_cl_r, out_raw_r};
  assign out_tuser  = out_st_r;

endmodule

@@ src/sgps_checker.sv @@
// Port-level assertions for the strip-chart point scaler, bound to the top level.
module sgps_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [sgps_pkg::FUNC_W-1:0]         in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [sgps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                out_tuser
);
  import sgps_pkg::*;

  localparam int ROW_LSB = 2 * VAL_W;

  logic [ROW_W-1:0] out_row;
  assign out_row = out_tdata[ROW_LSB+ROW_W-1:ROW_LSB];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a real item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_APPEND || in_tuser == FUNC_READ ||
    in_tuser == FUNC_RESTART) |=> !in_tready)
    else $error("input taken again right after an item transfer");

  // out-of-range read carries zero value and row
  a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[ROW_LSB+ROW_W-1:0] == '0)
    else $error("out-of-range read with nonzero payload");

  // good results land inside the plot rows
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_row >= ROW_W'(ROW_MARGIN) &&
    out_row <= ROW_W'(ROW_MARGIN + ROW_H))
    else $error("pixel row outside plot area");

endmodule

bind scrolling_graph_point_scaler sgps_checker u_sgps_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the strip-chart point scaler: predicted history and rows vs. DUT.
module tb;
  import sgps_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  sample;
    logic [IDX_W-1:0]  entry_index;
  } graph_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] raw_value;
    logic [VAL_W-1:0] clamped_value;
    logic [ROW_W-1:0] pixel_row;
    logic [CNT_W-1:0] point_count;
    logic             status;
  } graph_point_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [VAL_W-1:0]       cfg_data = '0;

  scrolling_graph_point_scaler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state
  int          reg_axis_low  = 0;
  int          reg_axis_high = 100;
  int unsigned reg_step      = 2;
  int          reg_zero      = 0;
  int          lim_low       = 0;
  int          lim_high      = 100;
  int          hist_raw     [MAX_POINTS];
  int          hist_clamped [MAX_POINTS];
  int unsigned hist_row     [MAX_POINTS];
  int unsigned oldest       = 0;
  int unsigned points_used  = 0;

  graph_item_t  pending_items[$];
  graph_point_t expected_points[$];
  graph_item_t  cur_item;

  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;
  int in_gap   = 0;
  int out_stall = 0;

  int errors = 0;
  int n_append = 0, n_read = 0, n_beyond = 0, n_restart = 0, n_unused = 0;
  int n_results = 0, n_cfg = 0, n_phases = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[scrolling_graph_point_scaler] ERROR");
    $finish;
  end

  function automatic int clamp_axis(int v);
    if (v > lim_high) v = lim_high;
    if (v < lim_low) v = lim_low;
    return v;
  endfunction

  function automatic int unsigned row_for(int v);
    longint span, rel, q;
    span = longint'(lim_high) - lim_low;
    rel  = longint'(v) - lim_low;
    q = 0;
    if (span != 0) q = (rel * ROW_H) / span;
    return int'(ROW_MARGIN + ROW_H - q);
  endfunction

  function automatic graph_point_t make_point(int raw, int cl, int unsigned row, bit st);
    graph_point_t p;
    p.raw_value     = raw[VAL_W-1:0];
    p.clamped_value = cl[VAL_W-1:0];
    p.pixel_row     = row[ROW_W-1:0];
    p.point_count   = points_used[CNT_W-1:0];
    p.status        = st;
    return p;
  endfunction

  function automatic void predict_point(graph_item_t it);
    int          smp, cl, z;
    int unsigned r, n, stp, p;
    smp = int'($signed(it.sample));
    case (it.func)
      FUNC_RESTART: begin
        n_restart++;
        stp = (reg_step < MIN_STEP) ? MIN_STEP : reg_step;
        n = (SCREEN_WIDTH - 2) / stp;
        if (n > MAX_POINTS) n = MAX_POINTS;
        if (reg_axis_low <= reg_axis_high) begin
          lim_low  = reg_axis_low;
          lim_high = reg_axis_high;
        end else begin
          lim_low  = reg_axis_high;
          lim_high = reg_axis_low;
        end
        z = clamp_axis(reg_zero);
        r = row_for(z);
        for (int i = 0; i < n; i++) begin
          hist_raw[i]     = z;
          hist_clamped[i] = z;
          hist_row[i]     = r;
        end
        points_used = n;
        oldest = 0;
        expected_points.push_back(make_point(z, z, r, 1'b0));
      end
      FUNC_APPEND: begin
        n_append++;
        cl = clamp_axis(smp);
        r = row_for(cl);
        if (points_used != 0) begin
          p = oldest % points_used;
          hist_raw[p]     = smp;
          hist_clamped[p] = cl;
          hist_row[p]     = r;
          p++;
          if (p >= points_used) p = 0;
          oldest = p;
        end
        expected_points.push_back(make_point(smp, cl, r, 1'b0));
      end
      FUNC_READ: begin
        n_read++;
        if (it.entry_index >= points_used) begin
          n_beyond++;
          expected_points.push_back(make_point(0, 0, 0, 1'b1));
        end else begin
          p = (oldest + it.entry_index) % points_used;
          expected_points.push_back(make_point(hist_raw[p], hist_clamped[p], hist_row[p], 1'b0));
        end
      end
      default: n_unused++;
    endcase
  endfunction

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_point(cur_item);
        in_gap = in_idle ? gap_len() : 0;
      end
      if (in_tvalid && !in_tready) begin
        // hold until transfer
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, cur_item.entry_index, cur_item.sample};
        in_tuser  <= cur_item.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    graph_point_t exp_p, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        got.raw_value     = out_tdata[15:0];
        got.clamped_value = out_tdata[31:16];
        got.pixel_row     = out_tdata[37:32];
        got.point_count   = out_tdata[43:38];
        got.status        = out_tuser;
        if (expected_points.size() == 0) begin
          report($sformatf("unexpected transfer raw=%0d", $signed(got.raw_value)));
        end else begin
          exp_p = expected_points.pop_front();
          if (got != exp_p)
            report($sformatf({"exp raw=%0d clamp=%0d row=%0d cnt=%0d st=%0d, ",
                              "got raw=%0d clamp=%0d row=%0d cnt=%0d st=%0d"},
                             $signed(exp_p.raw_value), $signed(exp_p.clamped_value),
                             exp_p.pixel_row, exp_p.point_count, exp_p.status,
                             $signed(got.raw_value), $signed(got.clamped_value),
                             got.pixel_row, got.point_count, got.status));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_idle) out_stall = gap_len();
      end
    end
  end

  task automatic push_item(logic [FUNC_W-1:0] f, int smp, int idx);
    graph_item_t it;
    it.func        = f;
    it.sample      = smp[VAL_W-1:0];
    it.entry_index = idx[IDX_W-1:0];
    pending_items.push_back(it);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[VAL_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_AXIS_LOW:  reg_axis_low  = val;
      REG_AXIS_HIGH: reg_axis_high = val;
      REG_STEP:      reg_step      = val & 'h7F;
      default:       reg_zero      = val;
    endcase
  endtask

  task automatic set_regs(int lo, int hi, int stp, int z);
    cfg_write(REG_AXIS_LOW, lo);
    cfg_write(REG_AXIS_HIGH, hi);
    cfg_write(REG_STEP, stp);
    cfg_write(REG_ZERO, z);
  endtask

  // all stimulus accepted, all results back, then settle
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_phases++;
  endtask

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_sample();
    int lo, hi, ext;
    lo = (reg_axis_low < reg_axis_high) ? reg_axis_low : reg_axis_high;
    hi = (reg_axis_low < reg_axis_high) ? reg_axis_high : reg_axis_low;
    ext = (hi - lo) / 4 + 2;
    if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom())));
    return sat16(lo - ext + int'($urandom_range(0, hi - lo + 2 * ext)));
  endfunction

  task automatic random_regs();
    int lo, hi, stp, z, t;
    case ($urandom_range(0, 3))
      0: begin
        lo = int'($signed(16'($urandom())));
        hi = int'($signed(16'($urandom())));
      end
      1: begin
        lo = int'($signed(16'($urandom())));
        hi = sat16(lo + int'($urandom_range(0, 200)));
      end
      2: begin
        lo = -32768;
        hi = 32767;
      end
      default: begin
        hi = int'($signed(16'($urandom())));
        lo = sat16(hi + int'($urandom_range(1, 300)));
      end
    endcase
    t = $urandom_range(0, 9);
    if (t < 4) stp = $urandom_range(0, 10);
    else if (t < 8) stp = $urandom_range(11, 126);
    else stp = (t == 8) ? 126 : 0;
    if ($urandom_range(0, 2) == 0) z = int'($signed(16'($urandom())));
    else z = sat16(((lo < hi) ? lo : hi) + int'($urandom_range(0, 400)) - 200);
    set_regs(lo, hi, stp, z);
  endtask

  // last index a restart with the current registers gives, for index spread
  function automatic int points_guess();
    int unsigned stp, n;
    stp = (reg_step < MIN_STEP) ? MIN_STEP : reg_step;
    n = (SCREEN_WIDTH - 2) / stp;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return (n > 0) ? n - 1 : 0;
  endfunction

  task automatic random_phase(int count);
    int unsigned r;
    in_idle  = ($urandom_range(0, 3) != 0);
    out_idle = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 5) != 0) push_item(FUNC_RESTART, $urandom(), $urandom());
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 52) push_item(FUNC_APPEND, rand_sample(), $urandom());
      else if (r < 92)
        push_item(FUNC_READ, $urandom(),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, points_guess()));
      else if (r < 97) push_item(FUNC_RESTART, $urandom(), $urandom());
      else push_item(FUNC_UNUSED, $urandom(), $urandom());
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: appends, reads and an unused code with no history, then a restart, appends and reads
    push_item(FUNC_APPEND, -32768, 0);
    push_item(FUNC_APPEND, 32767, 63);
    push_item(FUNC_READ, 0, 0);
    push_item(FUNC_READ, -1, 63);
    push_item(FUNC_UNUSED, 1234, 5);
    push_item(FUNC_RESTART, 0, 0);
    push_item(FUNC_APPEND, 100, 0);
    push_item(FUNC_APPEND, 50, 0);
    push_item(FUNC_READ, 0, 0);
    push_item(FUNC_READ, 0, 62);
    push_item(FUNC_READ, 0, 63);
    drain();

    // swapped limits, step below minimum, zero above axis
    set_regs(500, -500, 0, 32767);
    push_item(FUNC_RESTART, 0, 0);
    push_item(FUNC_APPEND, -32768, 0);
    push_item(FUNC_APPEND, 32767, 0);
    push_item(FUNC_READ, 0, 62);
    push_item(FUNC_READ, 0, 1);
    drain();

    // zero span
    set_regs(7, 7, 1, -5);
    push_item(FUNC_RESTART, 0, 0);
    push_item(FUNC_APPEND, 7, 0);
    push_item(FUNC_APPEND, -1, 0);
    push_item(FUNC_READ, 0, 0);
    drain();

    // full axis, step 126: single point
    set_regs(-32768, 32767, 126, -32768);
    push_item(FUNC_RESTART, 0, 0);
    push_item(FUNC_APPEND, 32767, 0);
    push_item(FUNC_READ, 0, 0);
    push_item(FUNC_READ, 0, 1);
    push_item(FUNC_APPEND, -32768, 0);
    push_item(FUNC_READ, 0, 0);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      random_regs();
      random_phase(120);
    end

    $display("covered %0d appends, %0d reads (%0d beyond count), %0d restarts, %0d ignored",
             n_append, n_read, n_beyond, n_restart, n_unused);
    $display("%0d results checked over %0d phases, %0d register writes",
             n_results, n_phases, n_cfg);
    if (errors == 0) begin
      $display("[scrolling_graph_point_scaler] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[scrolling_graph_point_scaler] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sgps_pkg.sv
src/sgps_ram.sv
src/sgps_div.sv
src/scrolling_graph_point_scaler.sv
src/sgps_checker.sv
sim/tb.sv
